// ----- hdl/pgs_pkg.sv -----
`timescale 1ns / 1ps
package pgs_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 2'd1;

  localparam logic signed [63:0] DOT_RESET = {1'b1, 63'd0};

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
  } pgs_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [63:0] area;
    logic signed [63:0] extension;
    logic [31:0]        radius;
    logic               last;
  } pgs_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_C1,
    OP_MUL_C2,
    OP_CROSS,
    OP_NORM,
    OP_MUL_AA,
    OP_MUL_BB,
    OP_SQRT_EDGE,
    OP_DIV_X,
    OP_DIV_Y,
    OP_EMIT_EDGE,
    OP_MUL_DX,
    OP_MUL_DY,
    OP_DOT,
    OP_MUL_XX,
    OP_MUL_YY,
    OP_LSQ,
    OP_ADVANCE,
    OP_SQRT_RAD,
    OP_EMIT_SUM
  } pgs_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_C1,
    ST_C2,
    ST_CROSS,
    ST_NORM,
    ST_AA,
    ST_BB,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_DX_GO,
    ST_DX_WAIT,
    ST_DY_GO,
    ST_DY_WAIT,
    ST_EMIT,
    ST_VDX,
    ST_VDY,
    ST_VDOT,
    ST_VXX,
    ST_VYY,
    ST_VLSQ,
    ST_ADV,
    ST_RAD_GO,
    ST_RAD_WAIT,
    ST_SUM
  } pgs_state_t;

  typedef struct packed {
    pgs_op_t op;
    logic    closing;
  } pgs_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic fin;
    logic m_zero;
    logic norm_ok;
    logic sq_busy;
    logic dv_busy;
  } pgs_status_t;

  function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
    logic signed [63:0] r;
    if (v[64] != v[63]) begin
      r = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/pgs_isqrt.sv -----
`timescale 1ns / 1ps
module pgs_isqrt
  import pgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] v_r, v_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [34:0] rem_sh, trial, diff;

  // two radicand bits per step, one root bit
  always_comb begin
    rem_sh   = {rem_r, v_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = rem_sh - trial;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      v_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = {v_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = diff[32:0];
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[32:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ----- hdl/pgs_div.sv -----
`timescale 1ns / 1ps
module pgs_div
  import pgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [45:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [14:0] quo
);

  logic [32:0] rem_r, rem_nxt;
  logic [14:0] lo_r, lo_nxt;
  logic [14:0] q_r, q_nxt;
  logic [31:0] den_r, den_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] rem_sh;
  logic        ge;

  // restoring division, quotient known to fit 15 bits
  always_comb begin
    rem_sh   = {rem_r[31:0], lo_r[14]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = {2'b00, num[45:15]};
      lo_nxt   = num[14:0];
      q_nxt    = '0;
      den_nxt  = den;
      cnt_nxt  = 4'd14;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      lo_nxt  = {lo_r[13:0], 1'b0};
      q_nxt   = {q_r[13:0], ge};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

// ----- hdl/pgs_datapath.sv -----
`timescale 1ns / 1ps
module pgs_datapath
  import pgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  pgs_cmd_t             cmd,
  output pgs_status_t          status,
  input  pgs_in_t              in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  output pgs_out_t             out_item
);

  logic signed [31:0] dir_x_r, dir_y_r;
  logic signed [31:0] cur_x_r, cur_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic               fin_r, have_prev_r;
  logic signed [63:0] cross_r, best_dot_r;
  logic [63:0]        max_len_r;
  logic signed [63:0] t0_r, t1_r;
  logic [31:0]        ax_r, ay_r;
  logic               sdx_r, sdy_r;
  logic [14:0]        qx_r;
  logic               out_valid_r;
  pgs_out_t           out_r, out_nxt;

  logic signed [31:0] x0, y0, x1, y1;
  logic signed [32:0] ma, mb, dx, dy;
  logic signed [65:0] prod;
  logic [31:0]        m;
  logic signed [63:0] cterm, dot;
  logic [63:0]        sq_sum, rad_in;
  logic               sq_start, dv_start, sq_busy, dv_busy;
  logic [31:0]        sq_root;
  logic [45:0]        dv_num;
  logic [14:0]        dv_quo;
  logic signed [15:0] nx, ny;

  always_comb begin
    if (cmd.closing) begin
      x0 = cur_x_r;   y0 = cur_y_r;
      x1 = first_x_r; y1 = first_y_r;
    end else begin
      x0 = prev_x_r;  y0 = prev_y_r;
      x1 = cur_x_r;   y1 = cur_y_r;
    end
  end

  // one shared multiplier, product registered into t0 or t1
  always_comb begin
    case (cmd.op)
      OP_MUL_C1: begin ma = {x0[31], x0}; mb = {y1[31], y1}; end
      OP_MUL_C2: begin ma = {y0[31], y0}; mb = {x1[31], x1}; end
      OP_MUL_AA: begin ma = {1'b0, ax_r}; mb = {1'b0, ax_r}; end
      OP_MUL_BB: begin ma = {1'b0, ay_r}; mb = {1'b0, ay_r}; end
      OP_MUL_DX: begin ma = {dir_x_r[31], dir_x_r}; mb = {cur_x_r[31], cur_x_r}; end
      OP_MUL_DY: begin ma = {dir_y_r[31], dir_y_r}; mb = {cur_y_r[31], cur_y_r}; end
      OP_MUL_XX: begin ma = {cur_x_r[31], cur_x_r}; mb = {cur_x_r[31], cur_x_r}; end
      OP_MUL_YY: begin ma = {cur_y_r[31], cur_y_r}; mb = {cur_y_r[31], cur_y_r}; end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  assign prod   = ma * mb;
  assign dx     = {x1[31], x1} - {x0[31], x0};
  assign dy     = {y1[31], y1} - {y0[31], y0};
  assign m      = (ax_r > ay_r) ? ax_r : ay_r;
  assign cterm  = sat65({t0_r[63], t0_r} - {t1_r[63], t1_r});
  assign dot    = sat65({t0_r[63], t0_r} + {t1_r[63], t1_r});
  assign sq_sum = t0_r + t1_r;

  assign sq_start = (cmd.op == OP_SQRT_EDGE) || (cmd.op == OP_SQRT_RAD);
  assign rad_in   = (cmd.op == OP_SQRT_RAD) ? max_len_r : sq_sum;
  assign dv_start = (cmd.op == OP_DIV_X) || (cmd.op == OP_DIV_Y);
  // 16384 * ax (ay for the Y division) + floor(len / 2)
  assign dv_num = {((cmd.op == OP_DIV_Y) ? ay_r : ax_r), 14'd0} + {15'd0, sq_root[31:1]};

  pgs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (rad_in),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  pgs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (sq_root),
    .busy  (dv_busy),
    .quo   (dv_quo)
  );

  always_comb begin
    if (m == 32'd0) begin
      nx = '0;
      ny = '0;
    end else begin
      nx = sdy_r ? $signed({1'b0, dv_quo}) : -$signed({1'b0, dv_quo});
      ny = sdx_r ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
    end
  end

  always_comb begin
    out_nxt = '0;
    if (cmd.op == OP_EMIT_SUM) begin
      out_nxt.kind      = 1'b1;
      out_nxt.area      = cross_r >>> 1;
      out_nxt.extension = best_dot_r;
      out_nxt.radius    = sq_root;
      out_nxt.last      = 1'b1;
    end else begin
      out_nxt.normal_x  = nx;
      out_nxt.normal_y  = ny;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r     <= '0;
      dir_y_r     <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      cross_r     <= '0;
      best_dot_r  <= DOT_RESET;
      max_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT_EDGE) || (cmd.op == OP_EMIT_SUM);
      if (cfg_we) begin
        if (cfg_index == REG_DIR_X) begin
          dir_x_r <= cfg_data;
        end else if (cfg_index == REG_DIR_Y) begin
          dir_y_r <= cfg_data;
        end
      end
      case (cmd.op)
        OP_CROSS: cross_r <= sat65({cross_r[63], cross_r} + {cterm[63], cterm});
        OP_DOT: begin
          if (dot > best_dot_r) begin
            best_dot_r <= dot;
          end
        end
        OP_LSQ: begin
          if (sq_sum > max_len_r) begin
            max_len_r <= sq_sum;
          end
        end
        OP_ADVANCE: begin
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          have_prev_r <= 1'b1;
          if (!have_prev_r) begin
            first_x_r <= cur_x_r;
            first_y_r <= cur_y_r;
          end
        end
        OP_EMIT_SUM: begin
          have_prev_r <= 1'b0;
          cross_r     <= '0;
          best_dot_r  <= DOT_RESET;
          max_len_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cur_x_r <= in_item.vertex_x;
        cur_y_r <= in_item.vertex_y;
        fin_r   <= in_item.last_vertex;
      end
      OP_MUL_C1, OP_MUL_AA, OP_MUL_DX, OP_MUL_XX: t0_r <= prod[63:0];
      OP_MUL_C2, OP_MUL_BB, OP_MUL_DY, OP_MUL_YY: t1_r <= prod[63:0];
      OP_CROSS: begin
        ax_r  <= dx[32] ? 32'(-dx) : dx[31:0];
        ay_r  <= dy[32] ? 32'(-dy) : dy[31:0];
        sdx_r <= dx[32];
        sdy_r <= dy[32];
      end
      OP_NORM: begin
        if (m[31]) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
        end else if (m[31:22] == 10'd0) begin
          ax_r <= ax_r << 8;
          ay_r <= ay_r << 8;
        end else if (!m[30]) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end
      end
      OP_DIV_Y: qx_r <= dv_quo;
      OP_EMIT_EDGE, OP_EMIT_SUM: out_r <= out_nxt;
      default: ;
    endcase
  end

  assign status.have_prev = have_prev_r;
  assign status.fin       = fin_r;
  assign status.m_zero    = (m == 32'd0);
  assign status.norm_ok   = (m[31:30] == 2'b01);
  assign status.sq_busy   = sq_busy;
  assign status.dv_busy   = dv_busy;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- hdl/pgs_ctrl.sv -----
`timescale 1ns / 1ps
module pgs_ctrl
  import pgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  pgs_status_t status,
  output pgs_cmd_t    cmd
);

  pgs_state_t state_r, state_nxt;
  logic       closing_r, closing_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (start) state_nxt = status.have_prev ? ST_C1 : ST_VDX;
      ST_C1:       state_nxt = ST_C2;
      ST_C2:       state_nxt = ST_CROSS;
      ST_CROSS:    state_nxt = ST_NORM;
      ST_NORM: begin
        if (status.m_zero) begin
          state_nxt = ST_EMIT;
        end else if (status.norm_ok) begin
          state_nxt = ST_AA;
        end
      end
      ST_AA:       state_nxt = ST_BB;
      ST_BB:       state_nxt = ST_SQ_GO;
      ST_SQ_GO:    state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (!status.sq_busy) state_nxt = ST_DX_GO;
      ST_DX_GO:    state_nxt = ST_DX_WAIT;
      ST_DX_WAIT:  if (!status.dv_busy) state_nxt = ST_DY_GO;
      ST_DY_GO:    state_nxt = ST_DY_WAIT;
      ST_DY_WAIT:  if (!status.dv_busy) state_nxt = ST_EMIT;
      ST_EMIT:     state_nxt = closing_r ? ST_RAD_GO : ST_VDX;
      ST_VDX:      state_nxt = ST_VDY;
      ST_VDY:      state_nxt = ST_VDOT;
      ST_VDOT:     state_nxt = ST_VXX;
      ST_VXX:      state_nxt = ST_VYY;
      ST_VYY:      state_nxt = ST_VLSQ;
      ST_VLSQ:     state_nxt = ST_ADV;
      ST_ADV:      state_nxt = status.fin ? ST_C1 : ST_IDLE;
      ST_RAD_GO:   state_nxt = ST_RAD_WAIT;
      ST_RAD_WAIT: if (!status.sq_busy) state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // the closing edge runs from the last vertex back to the first
  always_comb begin
    closing_nxt = closing_r;
    if (state_r == ST_ADV && status.fin) begin
      closing_nxt = 1'b1;
    end else if (state_r == ST_SUM) begin
      closing_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd.closing = closing_r;
    unique case (state_r)
      ST_IDLE:   cmd.op = start ? OP_LOAD : OP_NONE;
      ST_C1:     cmd.op = OP_MUL_C1;
      ST_C2:     cmd.op = OP_MUL_C2;
      ST_CROSS:  cmd.op = OP_CROSS;
      ST_NORM:   cmd.op = OP_NORM;
      ST_AA:     cmd.op = OP_MUL_AA;
      ST_BB:     cmd.op = OP_MUL_BB;
      ST_SQ_GO:  cmd.op = OP_SQRT_EDGE;
      ST_DX_GO:  cmd.op = OP_DIV_X;
      ST_DY_GO:  cmd.op = OP_DIV_Y;
      ST_EMIT:   cmd.op = OP_EMIT_EDGE;
      ST_VDX:    cmd.op = OP_MUL_DX;
      ST_VDY:    cmd.op = OP_MUL_DY;
      ST_VDOT:   cmd.op = OP_DOT;
      ST_VXX:    cmd.op = OP_MUL_XX;
      ST_VYY:    cmd.op = OP_MUL_YY;
      ST_VLSQ:   cmd.op = OP_LSQ;
      ST_ADV:    cmd.op = OP_ADVANCE;
      ST_RAD_GO: cmd.op = OP_SQRT_RAD;
      ST_SUM:    cmd.op = OP_EMIT_SUM;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      closing_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      closing_r <= closing_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !closing_r) else $error("closing flag left set in idle");
  a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |=> state_r == ST_IDLE) else $error("summary not followed by idle");
`endif

endmodule

// ----- hdl/polygon_geometry_summary_top.sv -----
`timescale 1ns / 1ps
// polygon geometry unit: vertices enter one item at a time, clockwise, Q16.16
// input: in_item is taken at a clock edge with start high and busy low
// results: out_valid pulses for one cycle with out_item; the receiver cannot stall
// every vertex after the first gives one edge normal result (kind 0)
// the vertex with last_vertex set also gives the closing edge normal and then
// a summary (kind 1, last 1) with area, extension and bounding radius
// busy: a first vertex keeps busy high for its vertex steps, and no new item is
// taken until busy drops; a vertex with an edge keeps busy high longer, set by
// the 32-step square root, two 15-step divisions and the normalize steps; a
// zero-length edge skips the root and the divisions; the edge result comes before busy drops
// the last vertex adds the closing edge and a 32-step root for the radius;
// the summary comes out in the cycle in which busy drops
// config: cfg_valid/cfg_index/cfg_data write dir_x (index 0) or dir_y (index 1);
// cfg_ready is always high, other indexes are ignored
// reset (rst_n low, synchronous) clears direction and the open polygon
module polygon_geometry_summary_top
  import pgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pgs_in_t              in_item,
  output logic                 out_valid,
  output pgs_out_t             out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  pgs_cmd_t    cmd;
  pgs_status_t status;

  assign cfg_ready = 1'b1;

  pgs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  pgs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
